>>> design/spi_pkg.sv
package spi_pkg;

    // Widths of the plane registers and of the configuration port.
    localparam int NORMAL_WIDTH   = 18;
    localparam int OFFSET_WIDTH   = 32;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;

    // Register reset values.
    localparam logic signed [NORMAL_WIDTH-1:0] NORMAL_X_RESET     = 18'sd0;
    localparam logic signed [NORMAL_WIDTH-1:0] NORMAL_Y_RESET     = 18'sd0;
    localparam logic signed [NORMAL_WIDTH-1:0] NORMAL_Z_RESET     = 18'sd65536;
    localparam logic signed [OFFSET_WIDTH-1:0] PLANE_OFFSET_RESET = 32'sd0;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_NORMAL_Z     = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } reg_index_t;

endpackage

>>> design/spi_divider.sv
module spi_divider #(
    parameter int DW = 56,
    parameter int QW = 17,
    parameter int SW = 200
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] out_side
);

    // One restoring step per stage. The user must keep dividend <= divisor
    // (not enforced); the remainder then stays below it and fits DW bits.
    logic          vld_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          v_in;
        logic [DW:0]   trial;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   diff;
        logic          ge;

        // Stage inputs: the first stage takes the operands directly.
        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign trial   = {1'b0, dividend};
            assign den_in  = divisor;
            assign q_in    = '0;
            assign side_in = in_side;
        end
        else begin : g_next
            assign v_in    = vld_reg[k-1];
            assign trial   = {rem_reg[k-1], 1'b0};
            assign den_in  = den_reg[k-1];
            assign q_in    = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Trial subtraction decides one quotient bit.
        assign diff = trial - {1'b0, den_in};
        assign ge   = (trial >= {1'b0, den_in});

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        // Payload of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                den_reg[k]  <= den_in;
                quo_reg[k]  <= {q_in[QW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quotient  = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

>>> design/segment_plane_intersect.sv
// Throughput: one transaction per cycle while the output is not stalled; the divider
// retires one quotient bit per stage.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset clears all valid bits and loads the plane registers with normal (0, 0, 1)
// and offset 0.
module segment_plane_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spi_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [spi_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [spi_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 seg_valid,
    output logic                                 seg_stall,
    input  logic signed [COORD_WIDTH-1:0]        start_x,
    input  logic signed [COORD_WIDTH-1:0]        start_y,
    input  logic signed [COORD_WIDTH-1:0]        start_z,
    input  logic signed [COORD_WIDTH-1:0]        end_x,
    input  logic signed [COORD_WIDTH-1:0]        end_y,
    input  logic signed [COORD_WIDTH-1:0]        end_z,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic                                 hit,
    output logic signed [COORD_WIDTH-1:0]        isect_x,
    output logic signed [COORD_WIDTH-1:0]        isect_y,
    output logic signed [COORD_WIDTH-1:0]        isect_z
);

    import spi_pkg::*;

    localparam int PW = NORMAL_WIDTH + COORD_WIDTH;   // normal times coordinate
    localparam int OW = OFFSET_WIDTH + FRAC_BITS;     // offset aligned to products
    localparam int MW = (PW > OW) ? PW : OW;
    localparam int DW = MW + 3;                       // distance, with sum headroom
    localparam int QW = FRAC_BITS + 1;                // t in [0, 1]
    localparam int LW = COORD_WIDTH + 1;              // endpoint difference
    localparam int XW = LW + QW + 1;                  // difference times t
    localparam int HW = XW - FRAC_BITS;               // scaled step
    localparam int VW = COORD_WIDTH + 4;              // point before saturation
    localparam int SW = 1 + 3 * COORD_WIDTH + 3 * LW; // sideband through divider

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [NORMAL_WIDTH-1:0] normal_reg [3];
    logic signed [OFFSET_WIDTH-1:0] offset_reg;
    logic                           cfg_write;
    reg_index_t                     cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_index_t'(paddr[3:2]);

    // Register writes on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg[0] <= NORMAL_X_RESET;
            normal_reg[1] <= NORMAL_Y_RESET;
            normal_reg[2] <= NORMAL_Z_RESET;
            offset_reg    <= PLANE_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_NORMAL_X:     normal_reg[0] <= pwdata[NORMAL_WIDTH-1:0];
                REG_NORMAL_Y:     normal_reg[1] <= pwdata[NORMAL_WIDTH-1:0];
                REG_NORMAL_Z:     normal_reg[2] <= pwdata[NORMAL_WIDTH-1:0];
                REG_PLANE_OFFSET: offset_reg    <= pwdata[OFFSET_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (cfg_sel)
            REG_NORMAL_X:     prdata = APB_DATA_WIDTH'($unsigned(normal_reg[0]));
            REG_NORMAL_Y:     prdata = APB_DATA_WIDTH'($unsigned(normal_reg[1]));
            REG_NORMAL_Z:     prdata = APB_DATA_WIDTH'($unsigned(normal_reg[2]));
            REG_PLANE_OFFSET: prdata = APB_DATA_WIDTH'($unsigned(offset_reg));
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances unless the result is stalled.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic res_valid_reg;

    assign pipe_en   = !(res_valid_reg && res_stall);
    assign seg_stall = !pipe_en;

    // ------------------------------------------------------------------
    // Stage 1: six normal-coordinate products and endpoint differences.
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] pt0 [3];
    logic signed [COORD_WIDTH-1:0] pt1 [3];

    assign pt0[0] = start_x;
    assign pt0[1] = start_y;
    assign pt0[2] = start_z;
    assign pt1[0] = end_x;
    assign pt1[1] = end_y;
    assign pt1[2] = end_z;

    logic                          s1_valid_reg;
    logic signed [PW-1:0]          s1_prod0_reg [3];
    logic signed [PW-1:0]          s1_prod1_reg [3];
    logic signed [COORD_WIDTH-1:0] s1_start_reg [3];
    logic signed [LW-1:0]          s1_delta_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= seg_valid;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_s1
        logic signed [PW-1:0] prod0_next;
        logic signed [PW-1:0] prod1_next;
        logic signed [LW-1:0] delta_next;

        assign prod0_next = normal_reg[i] * pt0[i];
        assign prod1_next = normal_reg[i] * pt1[i];
        assign delta_next = LW'(pt1[i]) - LW'(pt0[i]);

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                s1_prod0_reg[i] <= prod0_next;
                s1_prod1_reg[i] <= prod1_next;
                s1_start_reg[i] <= pt0[i];
                s1_delta_reg[i] <= delta_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signed distances of both endpoints.
    // ------------------------------------------------------------------
    logic signed [OW-1:0]          offset_aligned;
    logic signed [DW-1:0]          s2_d0_next;
    logic signed [DW-1:0]          s2_d1_next;
    logic                          s2_valid_reg;
    logic signed [DW-1:0]          s2_d0_reg;
    logic signed [DW-1:0]          s2_d1_reg;
    logic signed [COORD_WIDTH-1:0] s2_start_reg [3];
    logic signed [LW-1:0]          s2_delta_reg [3];

    assign offset_aligned = {offset_reg, {FRAC_BITS{1'b0}}};
    assign s2_d0_next = DW'(offset_aligned) + DW'(s1_prod0_reg[0])
                      + DW'(s1_prod0_reg[1]) + DW'(s1_prod0_reg[2]);
    assign s2_d1_next = DW'(offset_aligned) + DW'(s1_prod1_reg[0])
                      + DW'(s1_prod1_reg[1]) + DW'(s1_prod1_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_d0_reg    <= s2_d0_next;
            s2_d1_reg    <= s2_d1_next;
            s2_start_reg <= s1_start_reg;
            s2_delta_reg <= s1_delta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: side test, |d0| and |d0| + |d1|.
    // With opposite signs the sum of magnitudes is the magnitude of d0 - d1.
    // ------------------------------------------------------------------
    logic                          neg0;
    logic                          neg1;
    logic [DW-1:0]                 s3_a_next;
    logic [DW-1:0]                 s3_s_next;
    logic                          s3_valid_reg;
    logic                          s3_hit_reg;
    logic [DW-1:0]                 s3_a_reg;
    logic [DW-1:0]                 s3_s_reg;
    logic signed [COORD_WIDTH-1:0] s3_start_reg [3];
    logic signed [LW-1:0]          s3_delta_reg [3];

    assign neg0      = s2_d0_reg[DW-1];
    assign neg1      = s2_d1_reg[DW-1];
    assign s3_a_next = neg0 ? $unsigned(-s2_d0_reg) : $unsigned(s2_d0_reg);
    assign s3_s_next = neg0 ? $unsigned(s2_d1_reg - s2_d0_reg)
                            : $unsigned(s2_d0_reg - s2_d1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_hit_reg   <= neg0 ^ neg1;
            s3_a_reg     <= s3_a_next;
            s3_s_reg     <= s3_s_next;
            s3_start_reg <= s2_start_reg;
            s3_delta_reg <= s2_delta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: t = floor(|d0| * 2^FRAC_BITS / (|d0| + |d1|)).
    // ------------------------------------------------------------------
    logic [SW-1:0]                 div_side_in;
    logic [SW-1:0]                 div_side_out;
    logic                          div_valid;
    logic [QW-1:0]                 div_q;
    logic                          div_hit;
    logic signed [COORD_WIDTH-1:0] div_start [3];
    logic signed [LW-1:0]          div_delta [3];

    // Pack the sideband that travels alongside the quotient.
    always_comb
    begin
        div_side_in[SW-1] = s3_hit_reg;
        for (int i = 0; i < 3; i++)
        begin
            div_side_in[3*LW + i*COORD_WIDTH +: COORD_WIDTH] = s3_start_reg[i];
            div_side_in[i*LW +: LW]                          = s3_delta_reg[i];
        end
    end

    spi_divider #(
        .DW (DW),
        .QW (QW),
        .SW (SW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_a_reg),
        .divisor   (s3_s_reg),
        .in_side   (div_side_in),
        .out_valid (div_valid),
        .quotient  (div_q),
        .out_side  (div_side_out)
    );

    // Unpack the sideband.
    always_comb
    begin
        div_hit = div_side_out[SW-1];
        for (int i = 0; i < 3; i++)
        begin
            div_start[i] = div_side_out[3*LW + i*COORD_WIDTH +: COORD_WIDTH];
            div_delta[i] = div_side_out[i*LW +: LW];
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: (end - start) * t, exact.
    // ------------------------------------------------------------------
    logic                          mu_valid_reg;
    logic                          mu_hit_reg;
    logic signed [XW-1:0]          mu_prod_reg  [3];
    logic signed [COORD_WIDTH-1:0] mu_start_reg [3];
    logic signed [QW:0]            t_signed;

    assign t_signed = {1'b0, div_q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            mu_valid_reg <= div_valid;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_mul
        logic signed [XW-1:0] prod_next;

        assign prod_next = div_delta[i] * t_signed;

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                mu_prod_reg[i]  <= prod_next;
                mu_start_reg[i] <= div_start[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            mu_hit_reg <= div_hit;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor shift, add start, saturate, zero when no hit.
    // ------------------------------------------------------------------
    logic                          hit_reg;
    logic signed [COORD_WIDTH-1:0] isect_reg  [3];
    logic signed [COORD_WIDTH-1:0] isect_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_out
        logic signed [HW-1:0] step;
        logic signed [VW-1:0] point;
        logic                 over_hi;
        logic                 over_lo;

        assign step    = HW'(mu_prod_reg[i] >>> FRAC_BITS);
        assign point   = VW'(mu_start_reg[i]) + VW'(step);
        assign over_hi = !point[VW-1] && (|point[VW-2:COORD_WIDTH-1]);
        assign over_lo = point[VW-1] && !(&point[VW-2:COORD_WIDTH-1]);

        always_comb
        begin
            if (!mu_hit_reg)
            begin
                isect_next[i] = '0;
            end
            else if (over_hi)
            begin
                isect_next[i] = COORD_MAX;
            end
            else if (over_lo)
            begin
                isect_next[i] = COORD_MIN;
            end
            else
            begin
                isect_next[i] = point[COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            res_valid_reg <= mu_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            hit_reg   <= mu_hit_reg;
            isect_reg <= isect_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign isect_x   = isect_reg[0];
    assign isect_y   = isect_reg[1];
    assign isect_z   = isect_reg[2];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An accepted segment always enters the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid && !seg_stall) |=> s1_valid_reg)
        else $error("accepted transaction did not enter the pipeline");

    // For a crossing segment the parameter t never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && div_hit) |-> (!div_q[QW-1] || (div_q[QW-2:0] == '0)))
        else $error("intersection parameter above one");

    // A miss reports the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !hit) |-> ((isect_x == '0) && (isect_y == '0) && (isect_z == '0)))
        else $error("nonzero point on a miss");

endmodule
